// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== design/cssm_pkg.sv =====
package cssm_pkg;

  // One result byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

  // One queue entry: the results caused by one input transfer.
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } entry_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/cssm_front.sv =====
module cssm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] in_byte
  input  logic                s_tlast,   // in_last
  input  cssm_pkg::q_status_t q_status,
  output logic                push,
  output cssm_pkg::entry_t    push_data
);
  import cssm_pkg::*;

  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChLbr   = 8'h7B;
  localparam logic [7:0] ChRbr   = 8'h7D;

  typedef enum logic [2:0] {
    M_FREE     = 3'd1,
    M_ATRULE   = 3'd2,
    M_SELECTOR = 3'd3,
    M_BLOCK    = 3'd4,
    M_DECL     = 3'd5,
    M_COMMENT  = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t mode;
    mode_t saved;
    logic  paren;
  } pstate_t;

  typedef struct packed {
    pstate_t    st;
    logic [7:0] ch;
    logic       eat;
  } pres_t;

  // Bytes below space other than newline become space, carriage return becomes newline.
  function automatic logic [7:0] translate(logic [7:0] b);
    if (b >= ChSp || b == ChNl) return b;
    if (b == ChCr) return ChNl;
    return ChSp;
  endfunction

  // One parser step on byte c with optional lookahead; ch of zero means no output.
  function automatic pres_t parse(pstate_t s, logic [7:0] c, logic [7:0] la, logic has_la);
    pres_t r;
    logic  la_star, la_slash, la_open, la_close, la_space;
    logic  do_sel, do_decl;
    la_star  = has_la && la == ChStar;
    la_slash = has_la && la == ChSlash;
    la_open  = has_la && la == ChLbr;
    la_close = has_la && la == ChRbr;
    la_space = has_la && la == ChSp;
    r.st = s;
    r.ch = c;
    r.eat = 1'b0;
    do_sel = 1'b0;
    do_decl = 1'b0;
    if (s.mode != M_COMMENT && c == ChSlash && la_star) begin
      r.st.saved = s.mode;
      r.st.mode = M_COMMENT;
    end
    case (r.st.mode)
      M_FREE: begin
        if (c == ChSp || c == ChNl) begin
          r.ch = 8'h00;
        end else if (c == ChAt) begin
          r.st.mode = M_ATRULE;
        end else begin
          r.st.mode = M_SELECTOR;
          do_sel = 1'b1;
        end
      end
      M_SELECTOR: do_sel = 1'b1;
      M_ATRULE: begin
        if (c == ChNl || c == ChSemi) begin
          r.st.mode = M_FREE;
          r.ch = ChSemi;
        end else if (c == ChLbr) begin
          r.st.mode = M_BLOCK;
        end
      end
      M_BLOCK: begin
        if (c == ChSp || c == ChNl) begin
          r.ch = 8'h00;
        end else if (c == ChRbr) begin
          r.st.mode = M_FREE;
        end else begin
          r.st.mode = M_DECL;
          do_decl = 1'b1;
        end
      end
      M_DECL: do_decl = 1'b1;
      M_COMMENT: begin
        if (c == ChStar && la_slash) begin
          r.eat = 1'b1;
          r.st.mode = r.st.saved;
        end
        r.ch = 8'h00;
      end
      default: ;
    endcase
    // Selector rules, reached directly or from free text.
    if (do_sel) begin
      if (c == ChLbr) r.st.mode = M_BLOCK;
      else if (c == ChNl) r.ch = 8'h00;
      else if (c == ChAt) r.st.mode = M_ATRULE;
      else if (c == ChSp && la_open) r.ch = 8'h00;
    end
    // Declaration rules, reached directly or from a block.
    if (do_decl) begin
      if (c == ChOpen) r.st.paren = 1'b1;
      if (!r.st.paren) begin
        if (c == ChSemi) begin
          r.st.mode = M_BLOCK;
          if (la_close) r.ch = 8'h00;
        end else if (c == ChRbr) begin
          r.st.mode = M_FREE;
        end else if (c == ChNl) begin
          r.ch = 8'h00;
        end else if (c == ChSp && la_space) begin
          r.ch = 8'h00;
        end
      end else if (c == ChClose) begin
        r.st.paren = 1'b0;
      end
    end
    return r;
  endfunction

  pstate_t    pstate;
  logic [7:0] held_byte;
  logic       held_valid;
  logic       drop_next;

  logic       accept;
  logic [7:0] b;
  pres_t      p1, p2;
  logic       use1, use2, eat;
  pstate_t    st1, st2;
  logic [7:0] c1, c2;
  logic       has1, has2;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign b        = translate(s_tdata);

  // The held byte is parsed with the new byte as lookahead; on the last byte
  // the new byte is parsed too, with no lookahead, unless the held byte ate it.
  assign p1   = parse(pstate, held_byte, b, 1'b1);
  assign use1 = held_valid && !drop_next;
  assign st1  = use1 ? p1.st : pstate;
  assign eat  = use1 && p1.eat;
  assign c1   = use1 ? p1.ch : 8'h00;
  assign p2   = parse(st1, b, 8'h00, 1'b0);
  assign use2 = s_tlast && !eat;
  assign st2  = use2 ? p2.st : st1;
  assign c2   = use2 ? p2.ch : 8'h00;
  assign has1 = c1 != 8'h00;
  assign has2 = c2 != 8'h00;

  // Build the queue entry for this transfer.
  assign push = accept && (s_tlast || has1);
  always_comb begin
    push_data.two = has1 && has2;
    push_data.r1  = '{data: c2, valid: 1'b1, last: 1'b1};
    if (has1) begin
      push_data.r0 = '{data: c1, valid: 1'b1, last: s_tlast && !has2};
    end else if (has2) begin
      push_data.r0 = '{data: c2, valid: 1'b1, last: 1'b1};
    end else begin
      push_data.r0 = '{data: 8'h00, valid: 1'b0, last: 1'b1};
    end
  end

  // Parser state and the pending byte advance on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate     <= '{mode: M_FREE, saved: M_FREE, paren: 1'b0};
      held_byte  <= 8'h00;
      held_valid <= 1'b0;
      drop_next  <= 1'b0;
    end else if (accept) begin
      pstate     <= s_tlast ? st2 : st1;
      held_byte  <= s_tlast ? 8'h00 : b;
      held_valid <= !s_tlast;
      drop_next  <= !s_tlast && eat;
    end
  end

endmodule

// ===== design/cssm_queue.sv =====
`include "assert_macros.svh"

module cssm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cssm_pkg::entry_t    push_data,
  input  logic                pop,
  output cssm_pkg::entry_t    head,
  output cssm_pkg::q_status_t status
);
  import cssm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign head         = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst, status.full, !push)
  `ASSERT_IMPL(a_no_underflow, clk, rst, status.empty, !pop)
  `ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, count == $past(count) + CW'(1))

endmodule

// ===== design/cssm_out.sv =====
`include "assert_macros.svh"

module cssm_out (
  input  logic                clk,
  input  logic                rst,
  input  cssm_pkg::entry_t    head,
  input  cssm_pkg::q_status_t q_status,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // [7:0] out_byte, [8] out_valid, [15:9] zero
  output logic                m_tlast    // out_last
);
  import cssm_pkg::*;

  logic    phase;
  logic    load;
  result_t sel;

  // Take the next result when the output register is free or being drained.
  assign load = !q_status.empty && (!m_tvalid || m_tready);
  assign sel  = phase ? head.r1 : head.r0;
  assign pop  = load && (phase || !head.two);

  // Output register and the pair phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load) phase <= !pop;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {7'b0, sel.valid, sel.data};
      m_tlast <= sel.last;
    end
  end

  `ASSERT_IMPL(a_phase_pair, clk, rst, phase, !q_status.empty && head.two)
  `ASSERT_NEXT(a_pair_end, clk, rst, phase && load, m_tlast)
  `ASSERT_IMPL(a_empty_is_end, clk, rst, m_tvalid && !m_tdata[8], m_tlast)

endmodule

// ===== design/css_minifier_stream_core.sv =====
// CSS minifier stream core. Raw CSS bytes enter on the s_ channel, one per
// transfer, with s_tlast on the final byte of a stream; minified bytes leave on
// the m_ channel with m_tlast on the final result of that stream. A stream whose
// end yields no byte still closes with one transfer that has out_valid (bit 8)
// clear. The core holds one byte for lookahead, so a non-final byte's result appears
// only after the next byte is taken; parser modes carry over between streams.
// An input byte is accepted every cycle while the result queue (QUEUE_DEPTH
// entries) has room. Each input causes zero, one or two results, and the output
// register sends one result per cycle while m_tready is high, so a byte with two
// results (only the final byte of a stream) takes two output transfers. A result
// passes through the result queue and the output register to the m_ port.
module css_minifier_stream_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] out_valid, [15:9] zero
  output logic        m_tlast    // out_last
);
  import cssm_pkg::*;

  logic      push;
  entry_t    push_data;
  logic      pop;
  entry_t    head;
  q_status_t q_status;

  // Parser front end.
  cssm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Result queue between the parser and the output stage.
  cssm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Output stage.
  cssm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
